// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

	localparam int unsigned HASH_WORDS  = 8;
	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_START   = 56;   // first byte of the length field
	localparam int unsigned RND_W       = $clog2(ROUNDS);
	localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES);
	localparam int unsigned IDX_W       = $clog2(HASH_WORDS);

	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	localparam logic [31:0] H_INIT [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_ROUND [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef logic [31:0] word_t;

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: rtl/core/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// item      item_valid / item_stall     mode, data_byte
// digest    digest_valid / digest_stall digest_word, word_index, last_word
//
// A data byte is taken while the block is idle; the byte that completes a block
// also runs 64 rounds through the single round unit plus one chaining update.
// A finish item shifts in one pad byte per cycle up to the block end, then
// the rounds and update for each padded block (one or two), then eight digest words.
// Reset clears all control state and loads the initial hash values.
// item_stall is high whenever the block is busy; digest_stall holds the word.

`include "assert_macros.svh"

module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PAD    = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	localparam int unsigned NW = sha_pkg::HASH_WORDS;

	state_t state_q, ret_q;
	logic [sha_pkg::FILL_W-1:0] fill_q;
	logic [sha_pkg::RND_W-1:0]  rnd_q;
	logic [sha_pkg::IDX_W-1:0]  idx_q;
	logic [63:0]  bits_q;
	logic         first_q;
	logic         len_blk_q;
	logic [511:0] win_q;
	sha_pkg::word_t chain_q [NW];
	sha_pkg::word_t wv_q [NW];

	logic           accept;
	logic           fill_last;
	logic [7:0]     pad_byte;
	sha_pkg::word_t sched_new;
	sha_pkg::word_t t1;
	sha_pkg::word_t t2;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign fill_last    = (fill_q == sha_pkg::FILL_W'(sha_pkg::BLOCK_BYTES - 1));
	assign digest_valid = (state_q == ST_EMIT);
	assign digest_word  = chain_q[idx_q];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == sha_pkg::IDX_W'(NW - 1));

	// pad byte: 0x80 first, then zeros, length big-endian in the last eight bytes
	always_comb begin
		if (first_q) begin
			pad_byte = sha_pkg::PAD_BYTE;
		end else if (len_blk_q && (fill_q >= sha_pkg::FILL_W'(sha_pkg::LEN_START))) begin
			pad_byte = bits_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// message schedule: window word 0 is w[t], word i is w[t+i]
	assign sched_new = sha_pkg::small_sigma1(win_q[63:32]) + win_q[223:192]
		+ sha_pkg::small_sigma0(win_q[479:448]) + win_q[511:480];

	// shared round unit
	assign t1 = wv_q[7] + sha_pkg::big_sigma1(wv_q[4])
		+ ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
		+ sha_pkg::K_ROUND[rnd_q] + win_q[511:480];
	assign t2 = sha_pkg::big_sigma0(wv_q[0])
		+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			fill_q    <= '0;
			rnd_q     <= '0;
			idx_q     <= '0;
			bits_q    <= '0;
			first_q   <= 1'b0;
			len_blk_q <= 1'b0;
			chain_q   <= sha_pkg::H_INIT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !mode) begin
						if (fill_last) begin
							fill_q  <= '0;
							bits_q  <= bits_q + sha_pkg::BLOCK_BITS;
							ret_q   <= ST_IDLE;
							state_q <= ST_ROUND;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end else if (accept) begin
						bits_q    <= bits_q + {{(61 - sha_pkg::FILL_W){1'b0}}, fill_q, 3'b000};
						first_q   <= 1'b1;
						len_blk_q <= (fill_q < sha_pkg::FILL_W'(sha_pkg::LEN_START));
						state_q   <= ST_PAD;
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (fill_last) begin
						fill_q    <= '0;
						ret_q     <= len_blk_q ? ST_EMIT : ST_PAD;
						len_blk_q <= 1'b1;
						state_q   <= ST_ROUND;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == sha_pkg::RND_W'(sha_pkg::ROUNDS - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					for (int i = 0; i < NW; i++) begin
						chain_q[i] <= chain_q[i] + wv_q[i];
					end
					state_q <= ret_q;
				end
				ST_EMIT: begin
					if (!digest_stall) begin
						if (last_word) begin
							idx_q   <= '0;
							chain_q <= sha_pkg::H_INIT;
							fill_q  <= '0;
							bits_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block window and working variables
	always_ff @(posedge clk) begin
		if ((accept && !mode) || (state_q == ST_PAD)) begin
			win_q <= {win_q[503:0], (state_q == ST_PAD) ? pad_byte : data_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], sched_new};
		end
		if (state_q == ST_ROUND) begin
			wv_q <= '{t1 + t2, wv_q[0], wv_q[1], wv_q[2], wv_q[3] + t1,
				wv_q[4], wv_q[5], wv_q[6]};
		end else begin
			wv_q <= chain_q;
		end
	end

	`ASSERT_IMP(a_busy_when_emit, clk, arst_n, digest_valid, item_stall, "digest while ready")
	`ASSERT_IMP(a_rnd_idle, clk, arst_n, state_q != ST_ROUND, rnd_q == '0, "round count stray")
	`ASSERT_NXT(a_round_end, clk, arst_n,
		(state_q == ST_ROUND) && (rnd_q == sha_pkg::RND_W'(sha_pkg::ROUNDS - 1)),
		state_q == ST_UPDATE, "compression did not end after last round")
	`ASSERT_NXT(a_reinit, clk, arst_n, digest_valid && !digest_stall && last_word,
		(state_q == ST_IDLE) && (fill_q == '0) && (bits_q == '0) && (idx_q == '0),
		"message state not cleared after digest")

endmodule

// File: tb/sha256_digest_pkg.sv
`timescale 1ns / 1ps

package sha256_digest_pkg;

	import sha_pkg::*;

	typedef enum logic {
		ITEM_DATA   = 1'b0,
		ITEM_FINISH = 1'b1
	} item_mode_t;

	// one digest word as the block should present it
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	localparam int unsigned MAX_REPORTS = 10;

	// Tracks the running hash state and the digest words still owed by the block.
	class sha256_digest_tracker;
		logic [31:0]  chain [HASH_WORDS];
		logic [7:0]   blk [BLOCK_BYTES];
		logic [6:0]   fill;
		logic [63:0]  bit_len;
		digest_word_t words_due [$];
		int unsigned  mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			chain = H_INIT;
			fill = '0;
			bit_len = '0;
		endfunction

		function int unsigned pending();
			return words_due.size();
		endfunction

		static function logic [31:0] ror(logic [31:0] v, int unsigned n);
			logic [63:0] dbl;
			dbl = {v, v} >> n;
			return dbl[31:0];
		endfunction

		// 64-round compression of the held block into the chaining words
		function void compress();
			logic [31:0] w [ROUNDS];
			logic [31:0] s [HASH_WORDS];
			logic [31:0] x, y, t1, t2;
			int i;
			for (i = 0; i < 16; i++) begin
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			end
			for (i = 16; i < ROUNDS; i++) begin
				x = w[i-15];
				y = w[i-2];
				w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
					+ (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
			end
			s = chain;
			for (i = 0; i < ROUNDS; i++) begin
				t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
					+ ((s[4] & s[5]) ^ (~s[4] & s[6])) + K_ROUND[i] + w[i];
				t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
					+ ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
				s[7] = s[6];
				s[6] = s[5];
				s[5] = s[4];
				s[4] = s[3] + t1;
				s[3] = s[2];
				s[2] = s[1];
				s[1] = s[0];
				s[0] = t1 + t2;
			end
			for (i = 0; i < HASH_WORDS; i++) begin
				chain[i] = chain[i] + s[i];
			end
		endfunction

		// accepted input item: absorb a byte, or pad and queue the digest
		function void absorb(item_mode_t m, logic [7:0] b);
			int n;
			int i;
			digest_word_t rec;
			if (m == ITEM_DATA) begin
				blk[fill[5:0]] = b;
				fill = fill + 7'd1;
				if (fill >= BLOCK_BYTES) begin
					compress();
					bit_len = bit_len + BLOCK_BITS;
					fill = '0;
				end
				return;
			end
			n = fill[5:0];
			bit_len = bit_len + 64'(n) * 64'd8;
			blk[n] = PAD_BYTE;
			n++;
			// no room for the length: close this block and open another
			if (n > LEN_START) begin
				while (n < BLOCK_BYTES) begin
					blk[n] = 8'h00;
					n++;
				end
				compress();
				n = 0;
			end
			while (n < LEN_START) begin
				blk[n] = 8'h00;
				n++;
			end
			for (i = 0; i < 8; i++) begin
				blk[BLOCK_BYTES-1-i] = bit_len[8*i +: 8];
			end
			compress();
			for (i = 0; i < HASH_WORDS; i++) begin
				rec.word = chain[i];
				rec.idx = 3'(i);
				rec.last = (i == HASH_WORDS - 1);
				words_due.push_back(rec);
			end
			restart();
		endfunction

		// accepted digest word against the oldest one owed
		function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
			digest_word_t want;
			if (words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected digest word: word=%h idx=%0d last=%0b",
						word, idx, last);
				return;
			end
			want = words_due.pop_front();
			if (want.word !== word || want.idx !== idx || want.last !== last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("digest word wrong: expected word=%h idx=%0d last=%0b,",
						want.word, want.idx, want.last,
						" got word=%h idx=%0d last=%0b", word, idx, last);
			end
		endfunction
	endclass

endpackage

// File: tb/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

	import sha256_digest_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned RAND_ITEMS   = 210;
	localparam int unsigned MIN_DIGESTS  = 6;
	localparam int unsigned QUIET_AFTER  = 170;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic        mode         = ITEM_DATA;
	logic [7:0]  data_byte    = 8'h00;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_digest_tracker hash_track;
	bit          quiet = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;

	sha256_stream_hasher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.data_byte    (data_byte),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// digest side: check accepted words, then pick the next stall value
	always @(posedge clk) begin
		logic stall_next;
		if (arst_n && digest_valid && !digest_stall)
			hash_track.check_word(digest_word, word_index, last_word);
		stall_next = 1'b0;
		if (stall_left > 0) begin
			stall_next = 1'b1;
			stall_left = stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_next = 1'b1;
			stall_left = $urandom_range(1, 17) - 1;
		end
		digest_stall <= stall_next;
	end

	// present one item, with an occasional idle burst ahead of it
	task automatic send_item(input item_mode_t m, input logic [7:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		data_byte <= b;
		do @(posedge clk); while (item_stall);
		hash_track.absorb(m, b);
		items_sent++;
	endtask

	task automatic send_message(input int len);
		int i;
		logic [7:0] b;
		for (i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hff;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_item(ITEM_DATA, b);
		end
		send_item(ITEM_FINISH, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int len;
		int unsigned digests;
		hash_track = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, back-to-back finishes, byte extremes, "abc"
		send_item(ITEM_FINISH, 8'h00);
		send_item(ITEM_FINISH, 8'hff);
		send_item(ITEM_DATA, 8'h00);
		send_item(ITEM_FINISH, 8'h00);
		send_item(ITEM_DATA, 8'hff);
		send_item(ITEM_FINISH, 8'h5a);
		send_item(ITEM_DATA, 8'h80);
		send_item(ITEM_FINISH, 8'h00);
		send_item(ITEM_DATA, 8'h61);
		send_item(ITEM_DATA, 8'h62);
		send_item(ITEM_DATA, 8'h63);
		send_item(ITEM_FINISH, 8'ha5);

		// random messages, weighted toward the pad and block boundaries
		digests = 0;
		while (items_sent < RAND_ITEMS || digests < MIN_DIGESTS) begin
			case ($urandom_range(0, 7))
				0: len = $urandom_range(0, 3);
				1: len = $urandom_range(55, 57);
				2: len = $urandom_range(63, 65);
				3: len = $urandom_range(119, 121);
				default: len = $urandom_range(0, 40);
			endcase
			if (items_sent >= QUIET_AFTER)
				quiet = 1'b1;
			send_message(len);
			digests++;
		end
		quiet = 1'b1;
		item_valid <= 1'b0;

		while (hash_track.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (hash_track.mismatches == 0 && hash_track.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
